// ===== rtl/dpq_pkg.sv =====
// shared constants and types for the deadline priority quantum unit
package dpq_pkg;

    localparam int MAX_TASKS = 64;
    localparam int TBL_AW    = $clog2(MAX_TASKS);
    localparam int CNT_W     = 7;
    localparam int PRI_W     = 24;
    localparam int TIME_W    = 16;
    localparam int ID_W      = 6;
    localparam int CFG_IW    = 3;
    localparam int CFG_DW    = 32;
    localparam int SUM_W     = 32;
    localparam int SQ_W      = 64;
    localparam int RAD_W     = 72;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int Z_W       = 11;
    localparam int QNT_W     = 12;

    localparam logic [Z_W-1:0] Z_CAP = 11'd1024;

    // reset values of the configuration registers
    localparam logic [31:0]       RST_COEF_SS   = 32'd35816;
    localparam logic [31:0]       RST_COEF_S    = 32'd34601652;
    localparam logic [31:0]       RST_COEF_DUR  = 32'd3546317;
    localparam logic [31:0]       RST_COEF_ARR  = 32'd3484892;
    localparam logic [PRI_W-1:0]  RST_INFEAS    = 24'd80000;
    localparam logic [7:0]        RST_QBASE     = 8'd16;

    // event kinds
    localparam logic ACT_ARRIVE   = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_COEF_SS   = 3'd0,
        CFG_COEF_S    = 3'd1,
        CFG_COEF_DUR  = 3'd2,
        CFG_COEF_ARR  = 3'd3,
        CFG_INFEAS    = 3'd4,
        CFG_QBASE     = 3'd5
    } cfg_idx_t;

endpackage

// ===== rtl/dpq_evt_if.sv =====
// event channel: one task event per beat
interface dpq_evt_if;
    import dpq_pkg::*;
    logic                valid;
    logic                ready;
    logic                action;
    logic [ID_W-1:0]     task_id;
    logic [TIME_W-1:0]   arrival_time;
    logic [TIME_W-1:0]   needed_time;
    logic [TIME_W-1:0]   deadline_time;

    modport source (output valid, action, task_id, arrival_time, needed_time,
                    deadline_time, input ready);
    modport sink   (input valid, action, task_id, arrival_time, needed_time,
                    deadline_time, output ready);
endinterface

// ===== rtl/dpq_res_if.sv =====
// result channel: one result per beat
interface dpq_res_if;
    import dpq_pkg::*;
    logic                valid;
    logic                ready;
    logic [PRI_W-1:0]    task_priority;
    logic [TIME_W-1:0]   slice_length;
    logic [TIME_W-1:0]   remaining_after;
    logic                task_done;
    logic [CNT_W-1:0]    active_tasks;

    modport source (output valid, task_priority, slice_length, remaining_after,
                    task_done, active_tasks, input ready);
    modport sink   (input valid, task_priority, slice_length, remaining_after,
                    task_done, active_tasks, output ready);
endinterface

// ===== rtl/dpq_cfg_if.sv =====
// configuration write channel
interface dpq_cfg_if;
    import dpq_pkg::*;
    logic                valid;
    logic                ready;
    logic [CFG_IW-1:0]   index;
    logic [CFG_DW-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/dpq_score.sv =====
// serial square root and short divide giving the capped standard score
module dpq_score
    import dpq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [RAD_W-1:0] radicand,
    input  logic [31:0]      absn,
    output logic             done,
    output logic [Z_W-1:0]   z
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROOT = 4'b0010,
        S_CHK  = 4'b0100,
        S_DIV  = 4'b1000
    } sc_state_t;

    sc_state_t            state_reg, state_next;
    logic [5:0]           cnt_reg;
    logic [RAD_W-1:0]     rad_reg;
    logic [ROOT_W+2:0]    rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [39:0]          num_reg;
    logic [ROOT_W+9:0]    dv_reg;
    logic [Z_W-1:0]       q_reg;
    logic                 done_reg;

    logic [ROOT_W+2:0]    rem_sh;
    logic [ROOT_W+2:0]    trial;
    logic                 take;
    logic [ROOT_W+10:0]   lim;

    // one result bit of the root per step
    assign rem_sh = {rem_reg[ROOT_W:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign take   = rem_sh >= trial;
    assign lim    = {root_reg, 11'd0};

    // state sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_ROOT;
            S_ROOT: if (cnt_reg == 6'd0) state_next = S_CHK;
            S_CHK:  if (root_reg != '0 && {7'd0, num_reg} < lim) state_next = S_DIV;
                    else state_next = S_IDLE;
            S_DIV:  if (cnt_reg == 6'd0) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_CHK && state_next == S_IDLE) ||
                         (state_reg == S_DIV && cnt_reg == 6'd0);
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                num_reg  <= {absn, 8'd0};
                cnt_reg  <= 6'(ROOT_W - 1);
            end
            S_ROOT:
            begin
                rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
                cnt_reg <= cnt_reg - 6'd1;
                if (take)
                begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                end
            end
            S_CHK:
            begin
                dv_reg  <= {root_reg, 10'd0};
                cnt_reg <= 6'd10;
                if (root_reg == '0)
                    q_reg <= '0;
                else if ({7'd0, num_reg} >= lim)
                    q_reg <= Z_CAP;
                else
                    q_reg <= '0;
            end
            S_DIV:
            begin
                cnt_reg <= cnt_reg - 6'd1;
                dv_reg  <= dv_reg >> 1;
                if ({6'd0, num_reg} >= dv_reg)
                begin
                    num_reg <= 40'({6'd0, num_reg} - dv_reg);
                    q_reg   <= {q_reg[Z_W-2:0], 1'b1};
                end
                else
                    q_reg   <= {q_reg[Z_W-2:0], 1'b0};
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign z    = (q_reg > Z_CAP) ? Z_CAP : q_reg;

endmodule

// ===== rtl/deadline_priority_quantum_unit.sv =====
// top level: task priority table, running statistics and slice sequencer
//
// Usage: task events enter on the evt channel (valid/ready), one result
// leaves on the res channel per event. Configuration writes go on the cfg
// channel, which is always ready; write it only while the block is idle.
// An arrive event forms the quadratic priority in registered multiply and
// accumulate steps, rounds it and squares it, then does the table write
// and statistics update; a slack that is not positive skips the priority
// multiplies. A dispatch event reads the priority table through its
// registered read port, forms the variance terms n*sq, sum*sum and n*p,
// then runs the score unit: 36 root steps plus 11 divide steps, the divide
// left out when the score saturates before it. A dispatch with zero
// variance skips the score unit.
// One event is worked on at a time; the next is taken once the result sits
// in the output register, even while the receiver stalls it. A result
// waiting behind a stalled receiver holds the sequencer in its last step.
// Reset clears the statistics and restores the configuration defaults;
// the priority table is not cleared, and dispatching a task never
// arrived reads an undefined priority.
module deadline_priority_quantum_unit
    import dpq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    dpq_evt_if.sink  evt,
    dpq_res_if.source res,
    dpq_cfg_if.sink  cfg
);

    typedef enum logic [16:0] {
        ST_IDLE    = 17'h00001,
        ST_A_SQ1   = 17'h00002,
        ST_A_SQ2   = 17'h00004,
        ST_A_LIN1  = 17'h00008,
        ST_A_LIN2  = 17'h00010,
        ST_A_LIN3  = 17'h00020,
        ST_A_LIN4  = 17'h00040,
        ST_A_RND   = 17'h00080,
        ST_A_PSQ   = 17'h00100,
        ST_D_RD    = 17'h00200,
        ST_D_NQ    = 17'h00400,
        ST_D_SS    = 17'h00800,
        ST_D_NP    = 17'h01000,
        ST_D_DIFF  = 17'h02000,
        ST_D_SCORE = 17'h04000,
        ST_D_QUANT = 17'h08000,
        ST_FIN     = 17'h10000
    } st_t;

    st_t                 state_reg, state_next;

    // configuration
    logic [31:0]         coef_ss_reg, coef_s_reg, coef_dur_reg, coef_arr_reg;
    logic [PRI_W-1:0]    infeas_reg;
    logic [7:0]          qbase_reg;

    // statistics
    logic [CNT_W-1:0]    cnt_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]     sq_reg;

    // priority table
    logic [PRI_W-1:0]    tbl_mem [MAX_TASKS];
    logic [PRI_W-1:0]    tbl_q_reg;

    // event and working registers
    logic                act_reg;
    logic [ID_W-1:0]     id_reg;
    logic [TIME_W-1:0]   t0_reg, need_reg, dl_reg;
    logic [63:0]         prod_reg;
    logic [63:0]         acc_reg;
    logic [RAD_W-1:0]    wide_reg;
    logic [30:0]         np_reg;
    logic [PRI_W-1:0]    p_reg;
    logic [Z_W-1:0]      z_reg;
    logic [QNT_W-1:0]    quant_reg;

    // result register
    logic                out_valid_reg;
    logic [PRI_W-1:0]    out_pri_reg;
    logic [TIME_W-1:0]   out_slice_reg, out_rem_reg;
    logic                out_done_reg;
    logic [CNT_W-1:0]    out_cnt_reg;

    logic                evt_acc;
    logic                id_ok;
    logic [TIME_W:0]     slack;
    logic                slack_pos;
    logic [63:0]         rnd;
    logic [PRI_W-1:0]    p_sat;
    logic [31:0]         absn_now;
    logic [TIME_W-1:0]   slice, rem_after;
    logic                done_now;
    logic                out_free;
    logic                fin_load;
    logic                sc_start, sc_done;
    logic [Z_W-1:0]      sc_z;
    logic [13:0]         zmul;
    logic [21:0]         qprod;
    logic [CNT_W-1:0]    cnt_next;

    assign evt.ready = (state_reg == ST_IDLE);
    assign evt_acc   = evt.valid && evt.ready;
    assign cfg.ready = 1'b1;

    assign id_ok     = {1'b0, id_reg} < (ID_W+1)'(MAX_TASKS);
    assign slack     = {1'b0, dl_reg} - {1'b0, need_reg};
    assign slack_pos = !slack[TIME_W] && (slack != '0);

    // round half up and saturate at 24 bits
    assign rnd   = acc_reg + 64'h0080_0000;
    assign p_sat = (rnd[63:48] != '0) ? '1 : rnd[47:24];

    // distance of n*p from the sum, handed to the score unit at its start
    assign absn_now = ({1'b0, np_reg} >= sum_reg) ? ({1'b0, np_reg} - sum_reg)
                                                   : (sum_reg - {1'b0, np_reg});

    assign zmul  = {z_reg, 3'b000} + {3'b000, z_reg} + 14'd1024;
    assign qprod = 22'(qbase_reg) * 22'(zmul);

    assign slice     = ({4'd0, need_reg} < {4'd0, quant_reg}) ? need_reg
                                                              : TIME_W'(quant_reg);
    assign rem_after = need_reg - slice;
    assign done_now  = (rem_after == '0);

    assign out_free  = !out_valid_reg || res.ready;
    assign fin_load  = (state_reg == ST_FIN) && out_free;
    assign sc_start  = (state_reg == ST_D_DIFF) && (wide_reg > {8'd0, prod_reg});

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_ss_reg  <= RST_COEF_SS;
            coef_s_reg   <= RST_COEF_S;
            coef_dur_reg <= RST_COEF_DUR;
            coef_arr_reg <= RST_COEF_ARR;
            infeas_reg   <= RST_INFEAS;
            qbase_reg    <= RST_QBASE;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_COEF_SS:  coef_ss_reg  <= cfg.data;
                CFG_COEF_S:   coef_s_reg   <= cfg.data;
                CFG_COEF_DUR: coef_dur_reg <= cfg.data;
                CFG_COEF_ARR: coef_arr_reg <= cfg.data;
                CFG_INFEAS:   infeas_reg   <= cfg.data[PRI_W-1:0];
                CFG_QBASE:    qbase_reg    <= cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // priority table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (fin_load && act_reg == ACT_ARRIVE && id_ok)
            tbl_mem[id_reg[TBL_AW-1:0]] <= p_reg;
        tbl_q_reg <= tbl_mem[evt.task_id[TBL_AW-1:0]];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (evt_acc)
                    state_next = (evt.action == ACT_ARRIVE) ? ST_A_SQ1 : ST_D_RD;
            ST_A_SQ1:   state_next = slack_pos ? ST_A_SQ2 : ST_A_PSQ;
            ST_A_SQ2:   state_next = ST_A_LIN1;
            ST_A_LIN1:  state_next = ST_A_LIN2;
            ST_A_LIN2:  state_next = ST_A_LIN3;
            ST_A_LIN3:  state_next = ST_A_LIN4;
            ST_A_LIN4:  state_next = ST_A_RND;
            ST_A_RND:   state_next = ST_A_PSQ;
            ST_A_PSQ:   state_next = ST_FIN;
            ST_D_RD:    state_next = ST_D_NQ;
            ST_D_NQ:    state_next = ST_D_SS;
            ST_D_SS:    state_next = ST_D_NP;
            ST_D_NP:    state_next = ST_D_DIFF;
            ST_D_DIFF:  state_next = sc_start ? ST_D_SCORE : ST_D_QUANT;
            ST_D_SCORE: if (sc_done) state_next = ST_D_QUANT;
            ST_D_QUANT: state_next = ST_FIN;
            ST_FIN:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // arithmetic steps, at most one registered multiply per step, two in the quantum step
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                act_reg  <= evt.action;
                id_reg   <= evt.task_id;
                t0_reg   <= evt.arrival_time;
                need_reg <= evt.needed_time;
                dl_reg   <= evt.deadline_time;
            end
            ST_A_SQ1:
            begin
                prod_reg <= {16'd0, 48'(coef_ss_reg) * 48'(slack[TIME_W-1:0])};
                p_reg    <= infeas_reg;
            end
            ST_A_SQ2:
                acc_reg  <= (64'(prod_reg[47:0]) * 64'(slack[TIME_W-1:0])) >> 4;
            ST_A_LIN1:
                prod_reg <= {16'd0, 48'(coef_s_reg) * 48'(slack[TIME_W-1:0])};
            ST_A_LIN2:
            begin
                acc_reg  <= acc_reg + prod_reg;
                prod_reg <= {16'd0, 48'(coef_dur_reg) * 48'(need_reg)};
            end
            ST_A_LIN3:
            begin
                acc_reg  <= acc_reg + prod_reg;
                prod_reg <= {16'd0, 48'(coef_arr_reg) * 48'(t0_reg)};
            end
            ST_A_LIN4:  acc_reg  <= acc_reg + prod_reg;
            ST_A_RND:   p_reg    <= p_sat;
            ST_A_PSQ:   prod_reg <= {16'd0, 48'(p_reg) * 48'(p_reg)};
            ST_D_RD:    p_reg    <= id_ok ? tbl_q_reg : '0;
            ST_D_NQ:    wide_reg <= RAD_W'(cnt_reg) * RAD_W'(sq_reg);
            ST_D_SS:    prod_reg <= 64'(sum_reg) * 64'(sum_reg);
            ST_D_NP:    np_reg   <= 31'(cnt_reg) * 31'(p_reg);
            ST_D_DIFF:  z_reg    <= '0;
            ST_D_SCORE: if (sc_done) z_reg <= sc_z;
            ST_D_QUANT:
            begin
                quant_reg <= qprod[21:10];
                prod_reg  <= {16'd0, 48'(p_reg) * 48'(p_reg)};
            end
            ST_FIN: ;
            default: ;
        endcase
    end

    // statistics update on the closing step
    always_comb
    begin
        cnt_next = cnt_reg;
        if (act_reg == ACT_ARRIVE)
        begin
            if (id_ok && cnt_reg < CNT_W'(MAX_TASKS))
                cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (done_now && id_ok && cnt_reg != '0)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
        end
        else if (fin_load)
        begin
            cnt_reg <= cnt_next;
            if (act_reg == ACT_ARRIVE)
            begin
                if (id_ok && cnt_reg < CNT_W'(MAX_TASKS))
                begin
                    sum_reg <= sum_reg + {8'd0, p_reg};
                    sq_reg  <= sq_reg + prod_reg;
                end
            end
            else if (done_now && id_ok && cnt_reg != '0)
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    sum_reg <= '0;
                    sq_reg  <= '0;
                end
                else
                begin
                    sum_reg <= sum_reg - {8'd0, p_reg};
                    sq_reg  <= sq_reg - prod_reg;
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_load)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            out_pri_reg <= p_reg;
            out_cnt_reg <= cnt_next;
            if (act_reg == ACT_ARRIVE)
            begin
                out_slice_reg <= '0;
                out_rem_reg   <= need_reg;
                out_done_reg  <= 1'b0;
            end
            else
            begin
                out_slice_reg <= slice;
                out_rem_reg   <= rem_after;
                out_done_reg  <= done_now;
            end
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.task_priority   = out_pri_reg;
    assign res.slice_length    = out_slice_reg;
    assign res.remaining_after = out_rem_reg;
    assign res.task_done       = out_done_reg;
    assign res.active_tasks    = out_cnt_reg;

    // standard score unit
    dpq_score u_score (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sc_start),
        .radicand (wide_reg - {8'd0, prod_reg}),
        .absn     (absn_now),
        .done     (sc_done),
        .z        (sc_z)
    );

    // checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_TASKS))
        else $error("active count above table size");

    a_empty_stats: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> (sum_reg == '0 && sq_reg == '0))
        else $error("statistics not clear with no active task");

    a_busy_score: assert property (@(posedge clk) disable iff (!rst_n)
        sc_start |=> !evt.ready)
        else $error("event taken while score unit runs");

    a_cnt_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cnt_reg) |-> $past(fin_load))
        else $error("active count changed outside the closing step");

endmodule
